// ----- sv/thkr_pkg.sv -----
`timescale 1ns / 1ps
// shared types, key codes and helpers for the tap/hold key remapper
package thkr_pkg;

  // key event values
  localparam logic [1:0] KV_UP     = 2'd0;
  localparam logic [1:0] KV_DOWN   = 2'd1;
  localparam logic [1:0] KV_REPEAT = 2'd2;

  // key codes used by the reset table
  localparam logic [15:0] KC_ESC   = 16'd1;
  localparam logic [15:0] KC_LCTL  = 16'd29;
  localparam logic [15:0] KC_BTICK = 16'd41;
  localparam logic [15:0] KC_SPC   = 16'd57;
  localparam logic [15:0] KC_CAPS  = 16'd58;

  // configuration register indexes
  localparam int          CFG_IDX_BITS = 2;
  localparam int          NUM_MAP_REGS = 3;
  localparam logic [1:0]  CFG_DELAY    = 2'd3;
  localparam int          CFG_DATA_BITS = 30;

  // token handed from cell to cell
  typedef struct packed {
    logic vld;
    logic flush;   // 0: match pass, 1: hold flush pass
    logic found;   // an earlier cell matched the key
    logic sent;    // hold_sent of the matched entry
    logic tmo;     // matched entry's press is older than the delay
  } thkr_tok_t;

  // state update for the matched entry
  typedef struct packed {
    logic set_held;
    logic clr_held;
    logic set_sent;
    logic clr_sent;
    logic stamp;
  } thkr_cmd_t;

  function automatic logic [47:0] pack_entry(input int cb, input logic [15:0] m,
                                             input logic [15:0] t, input logic [15:0] h);
    logic [47:0] r;
    r = 48'(m) | (48'(t) << cb) | (48'(h) << (2 * cb));
    return r;
  endfunction

endpackage

// ----- sv/thkr_cell.sv -----
`timescale 1ns / 1ps
// one table entry with its key state, one step of the match and flush chain
module thkr_cell #(
  parameter int                      CODE_BITS = 10,
  parameter logic [3*CODE_BITS-1:0]  INIT      = '0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [3*CODE_BITS-1:0]     cfg_entry,
  input  logic [15:0]                delay,
  input  logic [CODE_BITS-1:0]       key,
  input  logic [31:0]                now,
  input  logic                       adv,
  input  thkr_pkg::thkr_cmd_t        cmd,
  input  thkr_pkg::thkr_tok_t        tok_i,
  input  logic [CODE_BITS-1:0]       tap_i,
  input  logic [CODE_BITS-1:0]       hold_i,
  output thkr_pkg::thkr_tok_t        tok_o,
  output logic [CODE_BITS-1:0]       tap_o,
  output logic [CODE_BITS-1:0]       hold_o,
  output logic                       emit_o,
  output logic [CODE_BITS-1:0]       emit_code_o
);
  import thkr_pkg::*;

  logic [3*CODE_BITS-1:0] entry_r;
  logic                   held_r;
  logic                   sent_r;
  logic [31:0]            press_r;
  logic                   hit_r;
  thkr_tok_t              tok_r;
  thkr_tok_t              tok_nxt;
  logic [CODE_BITS-1:0]   tap_r;
  logic [CODE_BITS-1:0]   hold_r;
  logic [CODE_BITS-1:0]   tap_nxt;
  logic [CODE_BITS-1:0]   hold_nxt;
  logic [CODE_BITS-1:0]   f_match;
  logic [CODE_BITS-1:0]   f_tap;
  logic [CODE_BITS-1:0]   f_hold;
  logic                   hit;
  logic                   tmo_now;

  assign f_match = entry_r[CODE_BITS-1:0];
  assign f_tap   = entry_r[2*CODE_BITS-1:CODE_BITS];
  assign f_hold  = entry_r[3*CODE_BITS-1:2*CODE_BITS];

  // elapsed time wraps modulo 2^32
  assign tmo_now = (now - press_r) > 32'(delay);

  assign hit = tok_i.vld && !tok_i.flush && !tok_i.found && (f_match == key);

  // pending hold-down of this entry goes out when the flush token passes
  assign emit_o      = tok_i.vld && tok_i.flush && held_r && (f_hold != '0) && !sent_r;
  assign emit_code_o = f_hold;

  always_comb begin
    tok_nxt  = tok_i;
    tap_nxt  = tap_i;
    hold_nxt = hold_i;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.sent  = sent_r;
      tok_nxt.tmo   = tmo_now;
      tap_nxt       = f_tap;
      hold_nxt      = f_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= INIT;
      held_r  <= 1'b0;
      sent_r  <= 1'b0;
      press_r <= '0;
      hit_r   <= 1'b0;
      tok_r   <= '0;
    end else begin
      if (cfg_we) begin
        entry_r <= cfg_entry;
      end
      if (adv) begin
        tok_r <= tok_nxt;
        if (tok_i.vld && !tok_i.flush) begin
          hit_r <= hit;
        end
        if (emit_o) begin
          sent_r <= 1'b1;
        end
      end
      if (hit_r) begin
        if (cmd.set_held) held_r  <= 1'b1;
        if (cmd.clr_held) held_r  <= 1'b0;
        if (cmd.set_sent) sent_r  <= 1'b1;
        if (cmd.clr_sent) sent_r  <= 1'b0;
        if (cmd.stamp)    press_r <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tap_r  <= tap_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign tap_o  = tap_r;
  assign hold_o = hold_r;

endmodule

// ----- sv/tap_hold_key_remapper_unit.sv -----
`timescale 1ns / 1ps
// top level of the tap/hold key remapper: controller, output register and cell chain
//
// Usage:
//   in_*  : one key event per transaction (code, value, millisecond time).
//   out_* : remapped key events; out_tlast marks the final event caused by one
//           input, out_tuser flags an entry whose tap code is zero.
//   cfg_* : register writes, taken at any time but meant for idle periods;
//           index 0..2 write table entries, index 3 the hold delay.
// Each event walks a row of NUM_ENTRIES cells, one per cycle unless the output
// stalls, to find the first matching entry. When held dual-role keys must
// report their hold code first, a second token walks the row and each such
// cell emits one event.
// One output register holds a result; while it is full and out_tready is low
// the row and the controller's launch and emit steps stall, so nothing is
// lost. After reset the table holds its default mapping, all keys read as
// released and the output is empty.
module tap_hold_key_remapper_unit #(
  parameter int NUM_ENTRIES = 3,
  parameter int CODE_BITS   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // key_code[9:0], key_value[11:10], now_ms[43:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_code[9:0], out_value[11:10]
  output logic [0:0]  out_tuser,  // config_error[0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_data
);
  import thkr_pkg::*;

  localparam int EW = 3 * CODE_BITS;
  localparam int WB = (EW < CFG_DATA_BITS) ? EW : CFG_DATA_BITS;
  localparam int KB = (CODE_BITS < 10) ? CODE_BITS : 10;

  typedef enum logic [2:0] {
    S_IDLE, S_MGO, S_MRUN, S_DEC, S_FGO, S_FRUN, S_E1, S_E2
  } state_t;

  state_t                 state_r;
  logic [CODE_BITS-1:0]   key_r;
  logic [1:0]             val_r;
  logic [31:0]            now_r;
  logic [15:0]            delay_r;
  logic                   fnd_r;
  logic                   fsent_r;
  logic                   ftmo_r;
  logic [CODE_BITS-1:0]   ftap_r;
  logic [CODE_BITS-1:0]   fhold_r;
  logic [CODE_BITS-1:0]   e_code_r;
  logic [1:0]             e_val_r;
  logic                   e_err_r;
  logic                   e_two_r;
  logic                   out_vld_r;
  logic [9:0]             out_code_r;
  logic [1:0]             out_val_r;
  logic                   out_err_r;
  logic                   out_last_r;

  logic                   adv;
  logic [EW-1:0]          cfg_entry;
  logic [CODE_BITS-1:0]   key_in;
  logic [NUM_ENTRIES-1:0] cell_we;
  logic [NUM_ENTRIES-1:0] cell_emit;
  logic [CODE_BITS-1:0]   cell_emit_code [NUM_ENTRIES];
  thkr_tok_t              tok_c  [NUM_ENTRIES+1];
  logic [CODE_BITS-1:0]   tap_c  [NUM_ENTRIES+1];
  logic [CODE_BITS-1:0]   hold_c [NUM_ENTRIES+1];
  logic                   fl_vld;
  logic [CODE_BITS-1:0]   fl_code;
  thkr_cmd_t              d_cmd;
  thkr_cmd_t              cmd;
  logic                   d_flush;
  logic                   d_emit;
  logic                   d_two;
  logic [CODE_BITS-1:0]   d_code;
  logic [1:0]             d_val;
  logic                   d_err;
  logic                   out_ld;
  logic [9:0]             out_code_nxt;
  logic [1:0]             out_val_nxt;
  logic                   out_err_nxt;
  logic                   out_last_nxt;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_entry = EW'(cfg_data[WB-1:0]);
  assign key_in    = CODE_BITS'(in_tdata[KB-1:0]);

  // launch token for the head of the row
  always_comb begin
    tok_c[0]       = '0;
    tok_c[0].vld   = (state_r == S_MGO) || (state_r == S_FGO);
    tok_c[0].flush = (state_r == S_FGO);
    tap_c[0]       = '0;
    hold_c[0]      = '0;
  end

  assign cmd = (state_r == S_DEC) ? d_cmd : '0;

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    localparam logic [47:0] FULL =
      (i == 0) ? pack_entry(CODE_BITS, KC_SPC, KC_SPC, KC_LCTL) :
      (i == 1) ? pack_entry(CODE_BITS, KC_CAPS, KC_ESC, 16'd0) :
      (i == 2) ? pack_entry(CODE_BITS, KC_ESC, KC_BTICK, 16'd0) : 48'd0;

    if (i < NUM_MAP_REGS) begin : g_we
      assign cell_we[i] = cfg_valid && (cfg_index == CFG_IDX_BITS'(i));
    end else begin : g_nowe
      assign cell_we[i] = 1'b0;
    end

    thkr_cell #(
      .CODE_BITS (CODE_BITS),
      .INIT      (FULL[EW-1:0])
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cfg_we      (cell_we[i]),
      .cfg_entry   (cfg_entry),
      .delay       (delay_r),
      .key         (key_r),
      .now         (now_r),
      .adv         (adv),
      .cmd         (cmd),
      .tok_i       (tok_c[i]),
      .tap_i       (tap_c[i]),
      .hold_i      (hold_c[i]),
      .tok_o       (tok_c[i+1]),
      .tap_o       (tap_c[i+1]),
      .hold_o      (hold_c[i+1]),
      .emit_o      (cell_emit[i]),
      .emit_code_o (cell_emit_code[i])
    );
  end

  // only the cell holding the flush token can emit
  always_comb begin
    fl_vld  = 1'b0;
    fl_code = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      fl_vld  = fl_vld | cell_emit[i];
      fl_code = fl_code | (cell_emit[i] ? cell_emit_code[i] : '0);
    end
  end

  // action for the event once the match pass is done
  always_comb begin
    d_cmd   = '0;
    d_flush = 1'b0;
    d_emit  = 1'b0;
    d_two   = 1'b0;
    d_code  = key_r;
    d_val   = val_r;
    d_err   = 1'b0;
    if (!fnd_r) begin
      d_flush = (val_r == KV_DOWN);
      d_emit  = 1'b1;
    end else if (ftap_r == '0) begin
      d_emit = 1'b1;
      d_code = '0;
      d_val  = KV_UP;
      d_err  = 1'b1;
    end else if (fhold_r != '0) begin
      unique case (val_r)
        KV_DOWN: begin
          d_cmd.set_held = 1'b1;
          d_cmd.stamp    = 1'b1;
        end
        KV_UP: begin
          d_cmd.clr_held = 1'b1;
          if (fsent_r) begin
            d_cmd.clr_sent = 1'b1;
            d_emit         = 1'b1;
            d_code         = fhold_r;
            d_val          = KV_UP;
          end else if (!ftmo_r) begin
            d_flush = 1'b1;
            d_emit  = 1'b1;
            d_two   = 1'b1;
            d_code  = ftap_r;
            d_val   = KV_DOWN;
          end
        end
        KV_REPEAT: begin
          if (ftmo_r && !fsent_r) begin
            d_cmd.set_sent = 1'b1;
            d_emit         = 1'b1;
            d_code         = fhold_r;
            d_val          = KV_DOWN;
          end
        end
        default: begin
        end
      endcase
    end else begin
      d_flush = (val_r == KV_DOWN);
      d_emit  = 1'b1;
      d_code  = ftap_r;
    end
  end

  // next content of the output register
  always_comb begin
    out_ld       = 1'b0;
    out_code_nxt = 10'(e_code_r[KB-1:0]);
    out_val_nxt  = e_val_r;
    out_err_nxt  = e_err_r;
    out_last_nxt = !e_two_r;
    if (adv) begin
      if (fl_vld) begin
        out_ld       = 1'b1;
        out_code_nxt = 10'(fl_code[KB-1:0]);
        out_val_nxt  = KV_DOWN;
        out_err_nxt  = 1'b0;
        out_last_nxt = 1'b0;
      end else if (state_r == S_E1) begin
        out_ld = 1'b1;
      end else if (state_r == S_E2) begin
        // tap key goes back up
        out_ld       = 1'b1;
        out_val_nxt  = KV_UP;
        out_err_nxt  = 1'b0;
        out_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      delay_r   <= 16'd300;
    end else begin
      if (cfg_valid && (cfg_index == CFG_DELAY)) begin
        delay_r <= cfg_data[15:0];
      end
      if (out_ld) begin
        out_vld_r  <= 1'b1;
        out_code_r <= out_code_nxt;
        out_val_r  <= out_val_nxt;
        out_err_r  <= out_err_nxt;
        out_last_r <= out_last_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            key_r   <= key_in;
            val_r   <= in_tdata[11:10];
            now_r   <= in_tdata[43:12];
            state_r <= S_MGO;
          end
        end
        S_MGO: begin
          if (adv) state_r <= S_MRUN;
        end
        S_MRUN: begin
          if (tok_c[NUM_ENTRIES].vld && !tok_c[NUM_ENTRIES].flush) begin
            fnd_r   <= tok_c[NUM_ENTRIES].found;
            fsent_r <= tok_c[NUM_ENTRIES].sent;
            ftmo_r  <= tok_c[NUM_ENTRIES].tmo;
            ftap_r  <= tap_c[NUM_ENTRIES];
            fhold_r <= hold_c[NUM_ENTRIES];
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          e_code_r <= d_code;
          e_val_r  <= d_val;
          e_err_r  <= d_err;
          e_two_r  <= d_two;
          if (d_flush) begin
            state_r <= S_FGO;
          end else if (d_emit) begin
            state_r <= S_E1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_FGO: begin
          if (adv) state_r <= S_FRUN;
        end
        S_FRUN: begin
          if (tok_c[NUM_ENTRIES].vld && tok_c[NUM_ENTRIES].flush) state_r <= S_E1;
        end
        S_E1: begin
          if (adv) state_r <= e_two_r ? S_E2 : S_IDLE;
        end
        S_E2: begin
          if (adv) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_val_r, out_code_r};
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the tap/hold key remapper unit
module tb;
  import thkr_pkg::*;

  localparam int NENT           = 3;
  localparam int IDLE_MAX       = 14;
  localparam int SETTLE_CYCLES  = 30;
  localparam int LONG_HOLDOFF   = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 52;

  localparam logic [1:0] KV_RAW     = 2'd3;  // undefined value, plain keys pass it on
  localparam logic [1:0] CFG_ENTRY0 = 2'd0;
  localparam logic [1:0] CFG_ENTRY1 = 2'd1;
  localparam logic [1:0] CFG_ENTRY2 = 2'd2;

  localparam logic [9:0] K_ESC      = KC_ESC[9:0];
  localparam logic [9:0] K_LEFTCTRL = KC_LCTL[9:0];
  localparam logic [9:0] K_GRAVE    = KC_BTICK[9:0];
  localparam logic [9:0] K_SPACE    = KC_SPC[9:0];
  localparam logic [9:0] K_CAPSLOCK = KC_CAPS[9:0];

  typedef struct packed {
    logic [9:0] code;
    logic [1:0] value;
    logic       err;
    logic       last;
  } key_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [29:0] cfg_data;

  tap_hold_key_remapper_unit #(
    .NUM_ENTRIES(NENT),
    .CODE_BITS  (10)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // remapper state as the testbench sees it
  logic [29:0] map_q     [NENT];
  logic [15:0] delay_q;
  logic        held_q    [NENT];
  logic        sent_q    [NENT];
  logic [31:0] pressed_q [NENT];

  key_out_t    key_events_q[$];  // expected remapped events, oldest first
  key_out_t    step_q[$];
  int          fail_count;
  int          sent_items;
  int          rx_wait;
  int          rx_holdoff_req;
  int          idle_cycles;
  bit          quiet;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [9:0] ent_match(int i);
    return map_q[i][9:0];
  endfunction

  function automatic logic [9:0] ent_tap(int i);
    return map_q[i][19:10];
  endfunction

  function automatic logic [9:0] ent_hold(int i);
    return map_q[i][29:20];
  endfunction

  function automatic void reset_remap_state();
    for (int i = 0; i < NENT; i++) begin
      held_q[i]    = 1'b0;
      sent_q[i]    = 1'b0;
      pressed_q[i] = '0;
    end
    map_q[0] = {K_LEFTCTRL, K_SPACE, K_SPACE};
    map_q[1] = {10'd0, K_ESC, K_CAPSLOCK};
    map_q[2] = {10'd0, K_GRAVE, K_ESC};
    delay_q  = 16'd300;
  endfunction

  function automatic void put_event(logic [9:0] c, logic [1:0] v, logic e);
    key_out_t r;
    r.code  = c;
    r.value = v;
    r.err   = e;
    r.last  = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic bit hold_expired(int i, logic [31:0] t);
    logic [31:0] d;
    d = t - pressed_q[i];
    return d > {16'd0, delay_q};
  endfunction

  // held dual-role keys report their hold code before a press goes through
  function automatic void send_pending_holds();
    for (int i = 0; i < NENT; i++) begin
      if (held_q[i] && ent_hold(i) != '0 && !sent_q[i]) begin
        put_event(ent_hold(i), KV_DOWN, 1'b0);
        sent_q[i] = 1'b1;
      end
    end
  endfunction

  function automatic void remap_event(logic [9:0] code, logic [1:0] val, logic [31:0] t);
    int       hit;
    key_out_t r;
    hit = -1;
    step_q.delete();
    for (int i = NENT - 1; i >= 0; i--) begin
      if (ent_match(i) == code) hit = i;
    end
    if (hit < 0) begin
      if (val == KV_DOWN) send_pending_holds();
      put_event(code, val, 1'b0);
    end else if (ent_tap(hit) == '0) begin
      put_event('0, KV_UP, 1'b1);
    end else if (ent_hold(hit) == '0) begin
      if (val == KV_DOWN) send_pending_holds();
      put_event(ent_tap(hit), val, 1'b0);
    end else begin
      case (val)
        KV_DOWN: begin
          held_q[hit]    = 1'b1;
          pressed_q[hit] = t;
        end
        KV_UP: begin
          held_q[hit] = 1'b0;
          if (sent_q[hit]) begin
            put_event(ent_hold(hit), KV_UP, 1'b0);
            sent_q[hit] = 1'b0;
          end else if (!hold_expired(hit, t)) begin
            send_pending_holds();
            put_event(ent_tap(hit), KV_DOWN, 1'b0);
            put_event(ent_tap(hit), KV_UP, 1'b0);
          end
        end
        KV_REPEAT: begin
          // hold goes down on a late repeat even when the key is not held
          if (hold_expired(hit, t) && !sent_q[hit]) begin
            put_event(ent_hold(hit), KV_DOWN, 1'b0);
            sent_q[hit] = 1'b1;
          end
        end
        default: ;
      endcase
    end
    foreach (step_q[k]) begin
      r      = step_q[k];
      r.last = (k == step_q.size() - 1);
      key_events_q.push_back(r);
    end
  endfunction

  function automatic void report_bad(string what, key_out_t got, key_out_t want);
    fail_count++;
    if (fail_count <= 10)
      $display({"%s: got code %0d value %0d err %0b last %0b,",
                " expected code %0d value %0d err %0b last %0b"},
               what, got.code, got.value, got.err, got.last,
               want.code, want.value, want.err, want.last);
  endfunction

  // result checker
  always @(posedge clk) begin
    key_out_t got;
    key_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[9:0], out_tdata[11:10], out_tuser[0], out_tlast};
      if (key_events_q.size() == 0) begin
        report_bad("unexpected event", got, '0);
      end else begin
        want = key_events_q.pop_front();
        if (got.code !== want.code || got.value !== want.value ||
            got.err !== want.err || got.last !== want.last)
          report_bad("mismatch", got, want);
      end
      rx_wait = quiet ? 0 : $urandom_range(0, IDLE_MAX);
    end
  end

  // receiver ready, with an optional long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_holdoff_req > 0) begin
        out_tready = 1'b0;
        repeat (rx_holdoff_req) @(negedge clk);
        rx_holdoff_req = 0;
      end
      if (rx_wait > 0) begin
        out_tready = 1'b0;
        rx_wait--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic drive_key(input logic [9:0] code, input logic [1:0] val, input logic [31:0] t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'd0, t, val, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    remap_event(code, val, t);
    sent_items++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // all events out, and time for a key that causes nothing to finish
  task automatic wait_idle();
    while (key_events_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [29:0] val);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DELAY) delay_q = val[15:0];
    else map_q[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic advance_clock();
    if ($urandom_range(0, 24) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + 32'($urandom_range(0, 2 * int'(delay_q) + 2));
  endtask

  function automatic logic [29:0] rand_entry();
    logic [9:0] m;
    logic [9:0] tp;
    logic [9:0] hd;
    m  = ($urandom_range(0, 5) == 0) ? ent_match(0) : 10'($urandom);
    tp = ($urandom_range(0, 15) == 0) ? 10'd0 : 10'($urandom);
    hd = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom);
    return {hd, tp, m};
  endfunction

  task automatic test_default_mapping();
    drive_key(K_SPACE, KV_DOWN, 32'd1000);
    drive_key(K_SPACE, KV_UP, 32'd1100);
    drive_key(K_CAPSLOCK, KV_DOWN, 32'd1200);
    drive_key(K_CAPSLOCK, KV_UP, 32'd1210);
    drive_key(K_ESC, KV_REPEAT, 32'd1220);
    drive_key(10'd1023, KV_RAW, 32'd1230);
    drive_key(K_SPACE, KV_RAW, 32'd1240);
  endtask

  task automatic test_hold_timing();
    // tap across the time wrap
    drive_key(K_SPACE, KV_DOWN, 32'hFFFF_FF00);
    drive_key(K_SPACE, KV_UP, 32'h0000_0010);
    // repeat exactly at the delay is still a tap window
    drive_key(K_SPACE, KV_DOWN, 32'd5000);
    drive_key(K_SPACE, KV_REPEAT, 32'd5300);
    drive_key(K_SPACE, KV_REPEAT, 32'd5301);
    drive_key(K_SPACE, KV_UP, 32'd5400);
    // another press flushes the pending hold first
    drive_key(K_SPACE, KV_DOWN, 32'd6000);
    drive_key(10'd30, KV_DOWN, 32'd6010);
    drive_key(K_SPACE, KV_UP, 32'd6020);
    // late release with no repeat sends nothing
    drive_key(K_SPACE, KV_DOWN, 32'd7000);
    drive_key(K_SPACE, KV_UP, 32'd7400);
    // late repeat while released
    drive_key(K_SPACE, KV_REPEAT, 32'd9000);
    drive_key(K_SPACE, KV_UP, 32'd9010);
  endtask

  task automatic test_backpressure();
    wait_idle();
    rx_holdoff_req = LONG_HOLDOFF;
    for (int k = 0; k < 8; k++) begin
      drive_key(10'(200 + k), KV_DOWN, 32'd20000 + 32'(k));
      drive_key(10'(200 + k), KV_UP, 32'd20000 + 32'(k));
    end
    drive_key(K_SPACE, KV_DOWN, 32'd30000);
    drive_key(K_SPACE, KV_UP, 32'd30001);
    wait_idle();
  endtask

  task automatic test_table_extremes();
    write_reg(CFG_ENTRY0, 30'd0);
    write_reg(CFG_ENTRY1, 30'h3FFF_FFFF);
    write_reg(CFG_ENTRY2, {K_LEFTCTRL, K_GRAVE, K_CAPSLOCK});
    write_reg(CFG_DELAY, 30'd0);
    drive_key(10'd0, KV_DOWN, 32'd50);
    drive_key(10'd1023, KV_DOWN, 32'd100);
    drive_key(K_CAPSLOCK, KV_DOWN, 32'd100);
    drive_key(K_ESC, KV_DOWN, 32'd101);
    drive_key(K_CAPSLOCK, KV_UP, 32'd102);
    drive_key(10'd1023, KV_UP, 32'd103);
    drive_key(10'd1023, KV_DOWN, 32'd500);
    drive_key(10'd1023, KV_UP, 32'd500);
    write_reg(CFG_DELAY, 30'd65535);
    drive_key(K_CAPSLOCK, KV_DOWN, 32'hFFFF_0000);
    drive_key(K_CAPSLOCK, KV_UP, 32'hFFFF_FFFF);
  endtask

  // mostly press/repeat/release runs on table keys with random timing, some noise
  task automatic tap_hold_run();
    logic [9:0] key;
    int         n;
    key = ent_match($urandom_range(0, NENT - 1));
    advance_clock();
    drive_key(key, KV_DOWN, clock_ms);
    n = $urandom_range(0, 3);
    repeat (n) begin
      advance_clock();
      case ($urandom_range(0, 3))
        0: drive_key(key, KV_REPEAT, clock_ms);
        1: drive_key(10'($urandom), KV_DOWN, clock_ms);
        2: drive_key(10'($urandom), KV_UP, clock_ms);
        default: drive_key(ent_match($urandom_range(0, NENT - 1)), KV_DOWN, clock_ms);
      endcase
    end
    advance_clock();
    if ($urandom_range(0, 7) != 0) drive_key(key, KV_UP, clock_ms);
  endtask

  task automatic test_random_sessions();
    int target;
    for (int ph = 0; ph < 5; ph++) begin
      quiet = (ph == 0);
      write_reg(CFG_ENTRY0, rand_entry());
      write_reg(CFG_ENTRY1, rand_entry());
      write_reg(CFG_ENTRY2, rand_entry());
      case (ph)
        1:       write_reg(CFG_DELAY, 30'd65535);
        2:       write_reg(CFG_DELAY, 30'd0);
        default: write_reg(CFG_DELAY, 30'($urandom_range(1, 1500)));
      endcase
      target   = sent_items + PHASE_ITEMS;
      clock_ms = $urandom;
      while (sent_items < target) begin
        if ($urandom_range(0, 9) < 7) begin
          tap_hold_run();
        end else begin
          advance_clock();
          drive_key($urandom_range(0, 1) ? ent_match($urandom_range(0, NENT - 1))
                                         : 10'($urandom),
                    2'($urandom_range(0, 3)), clock_ms);
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_ENTRY0;
    cfg_data       = '0;
    fail_count     = 0;
    sent_items     = 0;
    rx_wait        = 0;
    rx_holdoff_req = 0;
    quiet          = 1'b0;
    clock_ms       = '0;
    reset_remap_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_mapping();
    test_hold_timing();
    test_backpressure();
    test_table_extremes();
    test_random_sessions();

    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
